[sv/sprite_frame_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Sprite frame sequencer assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sprite_frame_sequencer: assertion failed");
// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sprite_frame_sequencer: assertion failed");
`else
`define SFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, command and register codes, and default sizes.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // default sizes
    localparam int MAX_FRAMES_DEF = 64;
    localparam int DELAY_BITS_DEF = 16;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int US_W      = 16;
    localparam int SLOT_W    = 6;
    localparam int DMS_W     = 16;
    localparam int FRAME_W   = 6;
    localparam int LOOPS_W   = 16;
    localparam int SPEED_W   = 16;
    localparam int FCNT_W    = 7;
    localparam int TIMER_W   = 32;
    localparam int PROD_W    = US_W + SPEED_W;
    localparam int SPEED_FRAC = 8;
    localparam int INC_W     = PROD_W - SPEED_FRAC;
    localparam int CNT_W     = 5;               // counts TIMER_W remainder steps
    localparam int US_PER_MS = 1000;
    localparam int US_PER_MS_W = 10;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
    localparam logic [LOOPS_W-1:0] LOOPS_RESET = 16'd1;
    localparam logic [FCNT_W-1:0]  FCNT_RESET  = 7'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SPEED  = 2'd0,
        REG_LOOPS  = 2'd1,
        REG_FCOUNT = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_RD,
        S_DLY,
        S_CMP,
        S_MOD,
        S_OUT
    } t_state;

endpackage

[sv/sfs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps an animation by elapsed time scaled by a Q8.8 speed, with looping.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | transaction
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall  | tick, delay write, restart
//  out      | output    | o_out_valid / i_out_stall| frame, loop status
//  cfg      | input     | APB psel/penable/pwrite  | speed, loop limit, frames
//
// A tick runs a multiply and an add, then a table read, delay scaling and
// compare per frame stepped over; a held last frame is then drained by the
// bit-serial remainder unit. Other items go straight to the output state.
// Reset is synchronous; the delay table is not cleared and needs no sweep.
// Input is stalled while an item is in work; a result waits in the output
// register while the output side stalls.
// ----------------------------------------------------------------------------
`include "sprite_frame_sequencer_macros.svh"

module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [US_W-1:0]    i_elapsed_us,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [DMS_W-1:0]   i_delay_ms,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic               o_loop_ended,
    output logic [LOOPS_W-1:0] o_loops_left,
    output logic               o_finished,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int AW   = $clog2(MAX_FRAMES);
    localparam int DUSW = DELAY_BITS + US_PER_MS_W;
    localparam int CW   = ((DUSW > TIMER_W + 1) ? DUSW : TIMER_W + 1) + 1;

    // configuration registers
    logic [SPEED_W-1:0] r_speed;
    logic [LOOPS_W-1:0] r_loop_limit;
    logic [FCNT_W-1:0]  r_frame_count;

    // playback state
    t_state             r_state, n_state;
    logic [TIMER_W-1:0] r_timer;
    logic [AW-1:0]      r_frame;
    logic [LOOPS_W-1:0] r_rem_loops;
    logic               r_ended;
    logic               r_hold;

    // work registers
    logic [US_W-1:0]    r_elapsed;
    logic [INC_W-1:0]   r_inc;
    logic [DUSW-1:0]    r_dus;
    logic [TIMER_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;

    // output register
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_ended;
    logic [LOOPS_W-1:0] r_out_loops;
    logic               r_out_finished;

    logic               w_accept;
    logic               w_out_free;
    logic               w_cfg_wr;
    t_reg               w_reg;
    t_cmd               w_cmd;
    logic               w_ram_we;
    logic [DELAY_BITS-1:0] w_ram_rdata;
    logic [PROD_W-1:0]  w_prod;
    logic [DELAY_BITS-1:0] w_dly_eff;
    logic [DUSW-1:0]    w_dus;
    logic [FCNT_W-1:0]  w_fc_eff;
    logic [AW-1:0]      w_last;
    logic [LOOPS_W-1:0] w_restart_loops;
    logic [LOOPS_W-1:0] w_wr_loops;

    // shared add/subtract unit
    logic [CW-1:0]      u_a, u_b, u_res;
    logic               u_sub, u_lt;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_reg      = t_reg'(paddr[3:2]);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // last frame in use, frame count clamped to 1..MAX_FRAMES
    assign w_fc_eff = (r_frame_count == '0) ? FCNT_W'(1) : r_frame_count;
    assign w_last   = (32'(w_fc_eff) > MAX_FRAMES) ? AW'(MAX_FRAMES - 1)
                                                   : AW'(w_fc_eff - FCNT_W'(1));

    assign w_restart_loops = (r_loop_limit == '0) ? LOOPS_W'(1) : r_loop_limit;
    assign w_wr_loops      = (pwdata[LOOPS_W-1:0] == '0) ? LOOPS_W'(1)
                                                         : pwdata[LOOPS_W-1:0];

    // tick increment product and scaled frame delay
    assign w_prod    = PROD_W'(r_elapsed) * PROD_W'(r_speed);
    assign w_dly_eff = (w_ram_rdata == '0) ? DELAY_BITS'(1) : w_ram_rdata;
    assign w_dus     = DUSW'(w_dly_eff) * DUSW'(US_PER_MS);

    assign u_res = u_a + (u_b ^ {CW{u_sub}}) + CW'(u_sub);
    assign u_lt  = u_res[CW-1];

    // delay table
    sfs_ram #(
        .WIDTH (DELAY_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (DELAY_BITS'(i_delay_ms)),
        .i_raddr (r_frame),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_cmd == CMD_TICK) ? S_MUL : S_OUT;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_RD;
            S_RD:  n_state = S_DLY;
            S_DLY: n_state = r_hold ? S_MOD : S_CMP;
            S_CMP: n_state = u_lt ? S_OUT : S_RD;
            S_MOD: begin
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: handshake, table write, shared unit operands
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_ram_we   = 1'b0;
        u_a        = CW'(r_timer);
        u_b        = CW'(r_dus);
        u_sub      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                w_ram_we = w_accept && (w_cmd == CMD_WRITE) && (32'(i_slot) < MAX_FRAMES);
            end
            S_ADD: begin
                u_b   = CW'(r_inc);
                u_sub = 1'b0;
            end
            S_MOD: begin
                u_a = CW'({r_rem, r_timer[TIMER_W-1]});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // playback state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed       <= SPEED_RESET;
            r_loop_limit  <= LOOPS_RESET;
            r_frame_count <= FCNT_RESET;
            r_timer       <= '0;
            r_frame       <= '0;
            r_rem_loops   <= LOOPS_RESET;
            r_ended       <= 1'b0;
            r_hold        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ended <= 1'b0;
                        r_hold  <= 1'b0;
                        if (w_cmd == CMD_RESTART) begin
                            r_timer     <= '0;
                            r_frame     <= '0;
                            r_rem_loops <= w_restart_loops;
                        end
                    end
                end
                S_ADD: begin
                    // saturate on carry out of the timer width
                    r_timer <= u_res[TIMER_W] ? '1 : u_res[TIMER_W-1:0];
                end
                S_CMP: begin
                    if (!u_lt) begin
                        if (r_rem_loops == '0) begin
                            // no loops left: hold last frame, drain by remainder
                            r_frame <= w_last;
                            r_hold  <= 1'b1;
                        end else begin
                            r_timer <= u_res[TIMER_W-1:0];
                            if (r_frame < w_last) begin
                                r_frame <= r_frame + AW'(1);
                            end else begin
                                r_ended <= 1'b1;
                                if (r_rem_loops >= LOOPS_W'(2)) begin
                                    r_rem_loops <= r_rem_loops - LOOPS_W'(1);
                                    r_frame     <= '0;
                                end else begin
                                    r_rem_loops <= '0;
                                    r_frame     <= w_last;
                                end
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (r_cnt == '0) begin
                        r_timer <= u_lt ? u_a[TIMER_W-1:0] : u_res[TIMER_W-1:0];
                    end else begin
                        r_timer <= {r_timer[TIMER_W-2:0], 1'b0};
                    end
                end
                default: begin
                end
            endcase

            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_SPEED:  r_speed <= pwdata[SPEED_W-1:0];
                    REG_LOOPS: begin
                        r_loop_limit <= pwdata[LOOPS_W-1:0];
                        r_rem_loops  <= w_wr_loops;
                    end
                    REG_FCOUNT: r_frame_count <= pwdata[FCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // work registers: latched input, increment, scaled delay, remainder
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_elapsed <= i_elapsed_us;
        end
        if (r_state == S_MUL) begin
            r_inc <= w_prod[PROD_W-1:SPEED_FRAC];
        end
        if (r_state == S_DLY) begin
            r_dus <= w_dus;
        end
        if (r_state == S_CMP) begin
            r_rem <= '0;
            r_cnt <= CNT_W'(TIMER_W - 1);
        end
        if (r_state == S_MOD) begin
            r_rem <= u_lt ? u_a[TIMER_W-1:0] : u_res[TIMER_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_frame    <= FRAME_W'(r_frame);
            r_out_ended    <= r_ended;
            r_out_loops    <= r_rem_loops;
            r_out_finished <= (r_rem_loops == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out_frame;
    assign o_loop_ended  = r_out_ended;
    assign o_loops_left  = r_out_loops;
    assign o_finished    = r_out_finished;

    // register readback
    always_comb begin
        unique case (w_reg)
            REG_SPEED:  prdata = APB_DW'(r_speed);
            REG_LOOPS:  prdata = APB_DW'(r_loop_limit);
            REG_FCOUNT: prdata = APB_DW'(r_frame_count);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // checks; the hold flag only matters while a tick is in work
    `SFS_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    `SFS_ASSERT_IMPL(a_hold_no_loops, i_clk, i_rst_n, r_hold && r_state != S_IDLE, r_rem_loops == '0)
    `SFS_ASSERT_IMPL(a_delay_nonzero, i_clk, i_rst_n, r_state == S_CMP, r_dus != '0)
    `SFS_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == S_MOD, CW'(r_rem) < CW'(r_dus))
    `SFS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == S_OUT && w_out_free, o_out_valid && r_state == S_IDLE)

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives ticks, delay writes and restarts through the valid/stall input
// channel while stepping the speed, loop limit and frame count registers
// through several settings. Every result is checked field by field against
// a directed status or in-bench model of timer, frame stepping and loops.
// ----------------------------------------------------------------------------
module tb_top;
    import sfs_pkg::*;

    // a single tick may step some 80k frames, each with a table read, scaling and compare
    localparam int IDLE_LIMIT   = 1000000;  // cycles without any transaction
    localparam int ITEMS_PHASE  = 108;
    localparam int PHASES       = 12;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic               loop_ended;
        logic [LOOPS_W-1:0] loops_left;
        logic               finished;
    } frame_status_t;

    typedef struct {
        bit            is_cfg;
        t_reg          reg_sel;
        logic [31:0]   value;
        t_cmd          cmd;
        logic [US_W-1:0]   us;
        logic [SLOT_W-1:0] slot;
        logic [DMS_W-1:0]  dms;
        bit            typed;
        frame_status_t want;
    } plan_row_t;

    // clock, reset and block inputs
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [CMD_W-1:0]   i_cmd        = '0;
    logic [US_W-1:0]    i_elapsed_us = '0;
    logic [SLOT_W-1:0]  i_slot       = '0;
    logic [DMS_W-1:0]   i_delay_ms   = '0;
    logic               i_out_stall  = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [APB_AW-1:0]  paddr        = '0;
    logic [APB_DW-1:0]  pwdata       = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [FRAME_W-1:0] o_frame_index;
    logic               o_loop_ended;
    logic [LOOPS_W-1:0] o_loops_left;
    logic               o_finished;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // animation model state and register copies
    logic [SPEED_W-1:0] cfg_speed       = SPEED_RESET;
    logic [LOOPS_W-1:0] cfg_loop_limit  = LOOPS_RESET;
    logic [FCNT_W-1:0]  cfg_frame_count = FCNT_RESET;
    logic [TIMER_W-1:0] anim_timer      = '0;
    logic [FRAME_W-1:0] anim_frame      = '0;
    logic [LOOPS_W-1:0] anim_loops      = LOOPS_RESET;
    logic [DMS_W-1:0]   delay_tbl [MAX_FRAMES_DEF];
    bit                 slot_written [MAX_FRAMES_DEF];

    frame_status_t      pending_status [$];
    plan_row_t          plan [$];
    int                 mismatches  = 0;
    int                 idle_cycles = 0;
    int                 stall_left  = 0;
    bit                 steady_flow = 1'b0;

    sprite_frame_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_elapsed_us  (i_elapsed_us),
        .i_slot        (i_slot),
        .i_delay_ms    (i_delay_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frame_index (o_frame_index),
        .o_loop_ended  (o_loop_ended),
        .o_loops_left  (o_loops_left),
        .o_finished    (o_finished),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // index of the last frame in use; out-of-range counts are clamped
    function automatic int unsigned last_frame();
        int unsigned n;
        n = 32'(cfg_frame_count);
        if (n == 0) n = 1;
        if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
        return n - 1;
    endfunction

    // frame delay in microseconds; zero delay counts as 1 ms
    function automatic longint unsigned delay_in_us(logic [FRAME_W-1:0] f);
        longint unsigned d;
        d = 64'(delay_tbl[f]);
        if (d == 0) d = 1;
        return d * 64'(US_PER_MS);
    endfunction

    // applies one transaction to the animation state, returns the status
    function automatic frame_status_t advance_animation(t_cmd cmd,
            logic [US_W-1:0] us, logic [SLOT_W-1:0] slot, logic [DMS_W-1:0] dms);
        longint unsigned acc;
        longint unsigned step_us;
        int unsigned     last;
        frame_status_t   st;
        st.loop_ended = 1'b0;
        case (cmd)
            CMD_TICK: begin
                acc = 64'(us);
                acc = (acc * 64'(cfg_speed)) >> SPEED_FRAC;
                acc = acc + 64'(anim_timer);
                if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                last = last_frame();
                forever begin
                    step_us = delay_in_us(anim_frame);
                    if (acc < step_us) break;
                    // no loops left: park on the last frame, keep the remainder
                    if (anim_loops == 0) begin
                        anim_frame = last[FRAME_W-1:0];
                        acc = acc % delay_in_us(anim_frame);
                        break;
                    end
                    acc = acc - step_us;
                    if (anim_frame < last) begin
                        anim_frame = anim_frame + 1'b1;
                    end else begin
                        st.loop_ended = 1'b1;
                        if (anim_loops >= 2) begin
                            anim_loops = anim_loops - 1'b1;
                            anim_frame = '0;
                        end else begin
                            anim_loops = '0;
                            anim_frame = last[FRAME_W-1:0];
                        end
                    end
                end
                anim_timer = acc[TIMER_W-1:0];
            end
            CMD_WRITE: begin
                delay_tbl[slot]    = dms;
                slot_written[slot] = 1'b1;
            end
            CMD_RESTART: begin
                anim_timer = '0;
                anim_frame = '0;
                anim_loops = (cfg_loop_limit == 0) ? LOOPS_RESET : cfg_loop_limit;
            end
            default: ;
        endcase
        st.frame_index = anim_frame;
        st.loops_left  = anim_loops;
        st.finished    = (anim_loops == 0);
        return st;
    endfunction

    function automatic frame_status_t status(int f, bit e, int l, bit fin);
        frame_status_t st;
        st.frame_index = f[FRAME_W-1:0];
        st.loop_ended  = e;
        st.loops_left  = l[LOOPS_W-1:0];
        st.finished    = fin;
        return st;
    endfunction

    function automatic void add_item(t_cmd cmd, int us, int slot, int dms,
                                     bit typed, frame_status_t want);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.reg_sel = REG_SPEED;
        r.value = '0;
        r.cmd = cmd;
        r.us = us[US_W-1:0];
        r.slot = slot[SLOT_W-1:0];
        r.dms = dms[DMS_W-1:0];
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(t_reg sel, int value);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.value = value;
        r.cmd = CMD_TICK;
        r.us = '0;
        r.slot = '0;
        r.dms = '0;
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [DMS_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return DMS_W'($urandom_range(0, 50));
        if (r < 17) return DMS_W'($urandom_range(51, 1000));
        return DMS_W'($urandom);
    endfunction

    // one input transaction; model runs at the accepting edge
    task automatic play_item(t_cmd cmd, logic [US_W-1:0] us, logic [SLOT_W-1:0] slot,
                             logic [DMS_W-1:0] dms, bit typed, frame_status_t want);
        frame_status_t st;
        int            gap;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_elapsed_us <= us;
        i_slot       <= slot;
        i_delay_ms   <= dms;
        do @(posedge i_clk); while (o_in_stall);
        st = advance_animation(cmd, us, slot, dms);
        pending_status.push_back(typed ? want : st);
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // setup + access cycle; model registers follow the write
    task automatic write_register(t_reg sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_SPEED:  cfg_speed = value[SPEED_W-1:0];
            REG_LOOPS: begin
                cfg_loop_limit = value[LOOPS_W-1:0];
                anim_loops = (cfg_loop_limit == 0) ? LOOPS_RESET : cfg_loop_limit;
            end
            REG_FCOUNT: cfg_frame_count = value[FCNT_W-1:0];
            default: ;
        endcase
        // idle gap between back-to-back writes
        @(posedge i_clk);
    endtask

    // mostly ticks; a tick that would read an unwritten delay becomes a write
    task automatic random_item();
        int                pick;
        int                need;
        int                hole;
        t_cmd              cmd;
        logic [US_W-1:0]   us;
        logic [SLOT_W-1:0] slot;
        logic [DMS_W-1:0]  dms;
        pick = $urandom_range(0, 99);
        if (pick < 70)      cmd = CMD_TICK;
        else if (pick < 88) cmd = CMD_WRITE;
        else if (pick < 95) cmd = CMD_RESTART;
        else                cmd = CMD_NONE;
        us = ($urandom_range(0, 4) == 0) ? US_W'($urandom) : US_W'($urandom_range(0, 20000));
        slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom)
                                           : SLOT_W'($urandom_range(0, last_frame()));
        dms = pick_delay();
        if (cmd == CMD_TICK) begin
            need = int'(last_frame());
            if (int'(anim_frame) > need) need = int'(anim_frame);
            hole = -1;
            for (int i = need; i >= 0; i--)
                if (!slot_written[i]) hole = i;
            if (hole >= 0) begin
                cmd  = CMD_WRITE;
                slot = SLOT_W'(hole);
            end
        end
        play_item(cmd, us, slot, dms, 1'b0, '0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        frame_status_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                $error("result with no transaction pending");
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                check_field("frame_index", want.frame_index, o_frame_index);
                check_field("loop_ended", want.loop_ended, o_loop_ended);
                check_field("loops_left", want.loops_left, o_loops_left);
                check_field("finished", want.finished, o_finished);
            end
        end
    end

    // output side: random stall after each accepted result
    always @(posedge i_clk) begin
        int next_left;
        if (o_out_valid && !i_out_stall)
            next_left = steady_flow ? 0 : $urandom_range(0, 5);
        else if (stall_left > 0)
            next_left = stall_left - 1;
        else
            next_left = 0;
        stall_left  <= next_left;
        i_out_stall <= (next_left != 0);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [SPEED_W-1:0] ph_speed [PHASES];
        logic [LOOPS_W-1:0] ph_loops [PHASES];
        logic [FCNT_W-1:0]  ph_fcount [PHASES];

        foreach (slot_written[i]) slot_written[i] = 1'b0;
        foreach (delay_tbl[i]) delay_tbl[i] = '0;

        // directed sequence at reset settings, then register extremes
        add_item(CMD_RESTART, 0, 0, 0, 1, status(0, 0, 1, 0));
        add_item(CMD_NONE, 16'hA5C3, 6'h2A, 16'h5A3C, 1, status(0, 0, 1, 0));
        add_item(CMD_WRITE, 0, 0, 0, 1, status(0, 0, 1, 0));
        add_item(CMD_WRITE, 0, 63, 65535, 1, status(0, 0, 1, 0));
        add_item(CMD_WRITE, 0, 1, 2, 1, status(0, 0, 1, 0));
        add_item(CMD_WRITE, 0, 2, 1, 1, status(0, 0, 1, 0));
        add_item(CMD_WRITE, 0, 3, 0, 1, status(0, 0, 1, 0));
        add_item(CMD_TICK, 999, 0, 0, 1, status(0, 0, 1, 0));
        // zero delay acts as 1 ms: the single loop ends here
        add_item(CMD_TICK, 1, 0, 0, 1, status(0, 1, 0, 1));
        // finished: last frame held, large tick drained at once
        add_item(CMD_TICK, 65535, 0, 0, 1, status(0, 0, 0, 1));
        add_item(CMD_TICK, 0, 0, 0, 1, status(0, 0, 0, 1));
        add_cfg(REG_SPEED, 0);
        add_item(CMD_TICK, 65535, 0, 0, 1, status(0, 0, 0, 1));
        // top speed, loop limit zero taken as one, frame count zero as one
        add_cfg(REG_SPEED, 65535);
        add_cfg(REG_LOOPS, 0);
        add_cfg(REG_FCOUNT, 0);
        add_item(CMD_TICK, 65535, 0, 0, 1, status(0, 1, 0, 1));
        add_cfg(REG_SPEED, 256);
        add_cfg(REG_LOOPS, 65535);
        add_cfg(REG_FCOUNT, 4);
        add_item(CMD_RESTART, 0, 0, 0, 1, status(0, 0, 65535, 0));
        add_item(CMD_TICK, 3000, 0, 0, 0, '0);
        add_item(CMD_TICK, 1000, 0, 0, 0, '0);
        // frame count shrinks below the current frame
        add_cfg(REG_FCOUNT, 2);
        add_item(CMD_TICK, 1000, 0, 0, 0, '0);
        add_item(CMD_TICK, 2500, 0, 0, 0, '0);
        // frame count above the table size clamps to the table size
        add_cfg(REG_FCOUNT, 127);
        add_item(CMD_RESTART, 0, 0, 0, 1, status(0, 0, 65535, 0));
        add_item(CMD_WRITE, 0, 10, 32768, 0, '0);

        // fixed settings first, random ones after
        ph_speed[0] = 256;   ph_loops[0] = 3;     ph_fcount[0] = 4;
        ph_speed[1] = 512;   ph_loops[1] = 65535; ph_fcount[1] = 8;
        ph_speed[2] = 65535; ph_loops[2] = 2;     ph_fcount[2] = 2;
        ph_speed[3] = 0;     ph_loops[3] = 5;     ph_fcount[3] = 64;
        ph_speed[4] = 128;   ph_loops[4] = 1;     ph_fcount[4] = 1;
        ph_speed[5] = 1024;  ph_loops[5] = 40;    ph_fcount[5] = 127;
        for (int p = 6; p < PHASES; p++) begin
            ph_speed[p] = SPEED_W'($urandom_range(1, 1024));
            ph_loops[p] = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : LOOPS_W'($urandom_range(0, 12));
            ph_fcount[p] = ($urandom_range(0, 4) == 0) ? FCNT_W'($urandom_range(0, 127))
                                                       : FCNT_W'($urandom_range(1, 12));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_register(plan[i].reg_sel, plan[i].value);
            end else begin
                play_item(plan[i].cmd, plan[i].us, plan[i].slot, plan[i].dms,
                          plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_register(REG_SPEED, 32'(ph_speed[p]));
            write_register(REG_LOOPS, 32'(ph_loops[p]));
            write_register(REG_FCOUNT, 32'(ph_fcount[p]));
            steady_flow = (p % 4 == 2);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if ($urandom_range(0, 59) == 0) drain();
                random_item();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            $error("%0d results never arrived", pending_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sfs_pkg.sv
sv/sfs_ram.sv
sv/sprite_frame_sequencer.sv
dv/tb_top.sv
